[rtl/pqts_pkg.sv]
// Shared types, constants and helpers for the piecewise quintic trajectory sampler.
// No dependencies; used by pqts_step_unit and the top level.
package pqts_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int NCOEF        = 12;
  localparam int AXIS_COEFS   = 6;
  localparam int SEG_W        = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int SEGCNT_W     = $clog2(MAX_SEGMENTS + 1);
  localparam int CDEPTH       = MAX_SEGMENTS * NCOEF;
  localparam int CADDR_W      = $clog2(CDEPTH);
  localparam logic [2:0] TOP_POWER = 3'd5;

  typedef enum logic [2:0] {
    OP_WCOEF  = 3'd0,
    OP_WEND   = 3'd1,
    OP_COMMIT = 3'd2,
    OP_TRIG   = 3'd3,
    OP_SAMPLE = 3'd4
  } op_t;

  // Which derivative a polynomial pass produces; its value is also the lowest power used.
  typedef enum logic [1:0] {
    KIND_POS = 2'd0,
    KIND_VEL = 2'd1,
    KIND_ACC = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_C_RD,
    ST_C_CAP,
    ST_FIRST,
    ST_MUL_HI,
    ST_ADD,
    ST_STORE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic add;
  } step_ctl_t;

  // Derivative weight of the power-k coefficient: 1, k or k*(k-1).
  function automatic logic [4:0] coef_factor(input kind_t kind, input logic [2:0] k);
    logic [4:0] f;
    begin
      case (kind)
        KIND_POS: f = 5'd1;
        KIND_VEL: f = {2'b00, k};
        KIND_ACC: f = 5'({2'b00, k} * ({2'b00, k} - 5'd1));
        default:  f = 5'd0;
      endcase
      return f;
    end
  endfunction

  // Q32.32 to Q16.16, truncating toward zero and saturating.
  function automatic logic [31:0] to_q16(input logic [63:0] a);
    logic        neg;
    logic [63:0] m;
    logic [47:0] q;
    logic [31:0] r;
    begin
      neg = a[63];
      m   = neg ? (64'd0 - a) : a;
      q   = m[63:16];
      if (neg) begin
        if (q > 48'h0000_8000_0000) q = 48'h0000_8000_0000;
        r = 32'd0 - q[31:0];
      end else begin
        if (q > 48'h0000_7FFF_FFFF) q = 48'h0000_7FFF_FFFF;
        r = q[31:0];
      end
      return r;
    end
  endfunction

endpackage

[rtl/pqts_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module pqts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/pqts_step_unit.sv]
// Shared Horner step: acc = sat(sat(acc*tt/2^16) + coef), one 32x32 multiplier used twice.
// Depends on pqts_pkg for the step control struct.
module pqts_step_unit (
  input  logic                clk,
  input  pqts_pkg::step_ctl_t ctl,
  input  logic [63:0]         coef,
  input  logic [31:0]         tt_mag,
  input  logic                tt_neg,
  output logic [63:0]         acc
);

  logic [63:0] acc_r;
  logic [95:0] prod_r;
  logic        neg_r;
  logic [63:0] acc_mag;
  logic [31:0] half;
  logic [63:0] pp;
  logic [79:0] shifted;
  logic [63:0] mmag;
  logic [63:0] mterm;
  logic [64:0] sum;
  logic [63:0] sum_sat;

  assign acc_mag = acc_r[63] ? (64'd0 - acc_r) : acc_r;
  assign half    = ctl.mul_hi ? acc_mag[63:32] : acc_mag[31:0];
  assign pp      = {32'd0, half} * {32'd0, tt_mag};

  assign shifted = prod_r[95:16];
  assign mmag    = (|shifted[79:63]) ? 64'h7FFF_FFFF_FFFF_FFFF : {1'b0, shifted[62:0]};
  assign mterm   = neg_r ? (64'd0 - mmag) : mmag;
  assign sum     = {mterm[63], mterm} + {coef[63], coef};

  always_comb begin
    if (sum[64] != sum[63]) begin
      sum_sat = sum[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      sum_sat = sum[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_lo) begin
      prod_r <= {32'd0, pp};
      neg_r  <= acc_r[63] ^ tt_neg;
    end else if (ctl.mul_hi) begin
      prod_r <= prod_r + {pp, 32'd0};
    end
    if (ctl.load) begin
      acc_r <= coef;
    end else if (ctl.add) begin
      acc_r <= sum_sat;
    end
  end

  assign acc = acc_r;

endmodule

[rtl/piecewise_quintic_trajectory_sampler.sv]
// Piecewise quintic trajectory sampler: segment search and Horner evaluation on one step unit.
// A sample reads and compares the end time of each segment examined in the search, then,
// if a segment is found, evaluates six polynomials on a shared 32x32 multiplier, each
// Horner step multiplying in two halves before the add, then loads the output register.
// The input stalls for the whole of a sample. Reset (rst_n, synchronous) clears control
// state; coefficient and end-time memories hold nothing defined until written.
module piecewise_quintic_trajectory_sampler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [3:0]  in_segment,
  input  logic [3:0]  in_coef_index,
  input  logic [47:0] in_coef_value,
  input  logic [31:0] in_end_time,
  input  logic [4:0]  in_segment_count,
  input  logic [31:0] in_stamp,
  input  logic [31:0] in_meas_x,
  input  logic [31:0] in_meas_y,
  input  logic [31:0] in_meas_z,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_hold_height,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ready_res,
  output logic [31:0] out_pos_x,
  output logic [31:0] out_pos_y,
  output logic [31:0] out_pos_z,
  output logic [31:0] out_vel_x,
  output logic [31:0] out_vel_y,
  output logic [31:0] out_acc_x,
  output logic [31:0] out_acc_y,
  output logic [15:0] out_trajectory_number
);

  pqts_pkg::state_t  state_r, state_nxt;
  pqts_pkg::step_ctl_t ctl;

  logic [31:0] hold_height_r;
  logic [pqts_pkg::SEGCNT_W-1:0] active_r;
  logic [31:0] start_stamp_r;
  logic        start_valid_r, start_armed_r, init_r, out_en_r;
  logic [15:0] traj_r;

  logic [pqts_pkg::SEGCNT_W-1:0] i_r;
  logic [2:0]  k_r;
  logic        axis_r;
  pqts_pkg::kind_t kind_r;
  logic        empty_r;
  logic        out_valid_r;

  logic [31:0] dt_r, prev_r, tt_mag_r;
  logic        tt_neg_r;
  logic [pqts_pkg::SEG_W-1:0] seg_r;
  logic [31:0] meas_x_r, meas_y_r, meas_z_r;
  logic [63:0] coef_r;
  logic [31:0] res_r [6];

  logic [31:0] o_pos_x_r, o_pos_y_r, o_pos_z_r, o_vel_x_r, o_vel_y_r;
  logic [31:0] o_acc_x_r, o_acc_y_r;
  logic [15:0] o_traj_r;
  logic        o_ready_r;

  logic        in_acc, out_free;
  logic        is_sample, emit, seg_ok;
  logic [31:0] eff_start, dt;
  logic        found, last_seg;
  logic [pqts_pkg::SEGCNT_W-1:0] i_inc;
  logic [pqts_pkg::SEGCNT_W-1:0] commit_n;

  logic        end_we, coef_we;
  logic [pqts_pkg::SEG_W-1:0]   end_waddr, end_raddr;
  logic [pqts_pkg::CADDR_W-1:0] coef_waddr, coef_raddr;
  logic [31:0] end_rd;
  logic [47:0] coef_rd;
  logic [4:0]  factor;
  logic signed [53:0] scaled;
  logic [63:0] acc;
  logic [2:0]  low_k;
  logic [2:0]  res_idx;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != pqts_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  assign is_sample = (pqts_pkg::op_t'(in_op) == pqts_pkg::OP_SAMPLE);
  assign eff_start = start_armed_r ? in_stamp : start_stamp_r;
  assign emit      = init_r && (start_valid_r || start_armed_r) && out_en_r;
  assign dt        = in_stamp - eff_start;
  assign seg_ok    = ({1'b0, in_segment} < 5'(pqts_pkg::MAX_SEGMENTS));

  assign commit_n  = ({1'b0, in_segment_count} > 6'(pqts_pkg::MAX_SEGMENTS)) ?
                     pqts_pkg::SEGCNT_W'(pqts_pkg::MAX_SEGMENTS) :
                     pqts_pkg::SEGCNT_W'(in_segment_count);

  assign found     = dt_r < end_rd;
  assign i_inc     = i_r + 1'b1;
  assign last_seg  = (i_inc == active_r);
  assign low_k     = {1'b0, kind_r};
  assign res_idx   = axis_r ? (3'd3 + {1'b0, kind_r}) : {1'b0, kind_r};

  // Memories
  assign end_we     = in_acc && (pqts_pkg::op_t'(in_op) == pqts_pkg::OP_WEND) && seg_ok;
  assign end_waddr  = pqts_pkg::SEG_W'(in_segment);
  assign end_raddr  = i_r[pqts_pkg::SEG_W-1:0];
  assign coef_we    = in_acc && (pqts_pkg::op_t'(in_op) == pqts_pkg::OP_WCOEF) && seg_ok &&
                      (in_coef_index < 4'(pqts_pkg::NCOEF));
  assign coef_waddr = pqts_pkg::CADDR_W'(int'(in_segment) * pqts_pkg::NCOEF +
                                         int'(in_coef_index));
  assign coef_raddr = pqts_pkg::CADDR_W'(int'(seg_r) * pqts_pkg::NCOEF +
                                         int'(axis_r) * pqts_pkg::AXIS_COEFS + int'(k_r));

  pqts_ram #(.WIDTH(32), .DEPTH(pqts_pkg::MAX_SEGMENTS)) u_end_ram (
    .clk   (clk),
    .we    (end_we),
    .waddr (end_waddr),
    .wdata (in_end_time),
    .raddr (end_raddr),
    .rdata (end_rd)
  );

  pqts_ram #(.WIDTH(48), .DEPTH(pqts_pkg::CDEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (in_coef_value),
    .raddr (coef_raddr),
    .rdata (coef_rd)
  );

  assign factor = pqts_pkg::coef_factor(kind_r, k_r);
  assign scaled = $signed(coef_rd) * $signed({1'b0, factor});

  pqts_step_unit u_step (
    .clk    (clk),
    .ctl    (ctl),
    .coef   (coef_r),
    .tt_mag (tt_mag_r),
    .tt_neg (tt_neg_r),
    .acc    (acc)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      pqts_pkg::ST_IDLE: begin
        if (in_acc && is_sample && init_r && emit) begin
          state_nxt = (active_r == '0) ? pqts_pkg::ST_EMIT : pqts_pkg::ST_SRCH_RD;
        end
      end
      pqts_pkg::ST_SRCH_RD: begin
        state_nxt = pqts_pkg::ST_SRCH_CMP;
      end
      pqts_pkg::ST_SRCH_CMP: begin
        if (found) begin
          state_nxt = pqts_pkg::ST_C_RD;
        end else if (last_seg) begin
          state_nxt = pqts_pkg::ST_EMIT;
        end else begin
          state_nxt = pqts_pkg::ST_SRCH_RD;
        end
      end
      pqts_pkg::ST_C_RD: begin
        state_nxt = pqts_pkg::ST_C_CAP;
      end
      pqts_pkg::ST_C_CAP: begin
        ctl.mul_lo = (k_r != pqts_pkg::TOP_POWER);
        state_nxt  = (k_r == pqts_pkg::TOP_POWER) ? pqts_pkg::ST_FIRST : pqts_pkg::ST_MUL_HI;
      end
      pqts_pkg::ST_FIRST: begin
        ctl.load  = 1'b1;
        state_nxt = pqts_pkg::ST_C_RD;
      end
      pqts_pkg::ST_MUL_HI: begin
        ctl.mul_hi = 1'b1;
        state_nxt  = pqts_pkg::ST_ADD;
      end
      pqts_pkg::ST_ADD: begin
        ctl.add   = 1'b1;
        state_nxt = (k_r == low_k) ? pqts_pkg::ST_STORE : pqts_pkg::ST_C_RD;
      end
      pqts_pkg::ST_STORE: begin
        state_nxt = (axis_r && kind_r == pqts_pkg::KIND_ACC) ? pqts_pkg::ST_EMIT :
                    pqts_pkg::ST_C_RD;
      end
      pqts_pkg::ST_EMIT: begin
        if (out_free) state_nxt = pqts_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pqts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pqts_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_height_r <= 32'd131072;
      active_r      <= '0;
      start_stamp_r <= '0;
      start_valid_r <= 1'b0;
      start_armed_r <= 1'b0;
      init_r        <= 1'b0;
      out_en_r      <= 1'b0;
      traj_r        <= '0;
      i_r           <= '0;
      k_r           <= '0;
      axis_r        <= 1'b0;
      kind_r        <= pqts_pkg::KIND_POS;
      empty_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) hold_height_r <= cfg_hold_height;

      if (in_acc) begin
        case (pqts_pkg::op_t'(in_op))
          pqts_pkg::OP_COMMIT: begin
            if (out_en_r) begin
              active_r      <= commit_n;
              traj_r        <= traj_r + 16'd1;
              start_armed_r <= 1'b1;
            end
          end
          pqts_pkg::OP_TRIG: begin
            if (init_r) begin
              traj_r   <= traj_r + 16'd1;
              out_en_r <= 1'b1;
            end
          end
          pqts_pkg::OP_SAMPLE: begin
            if (start_armed_r) begin
              start_stamp_r <= in_stamp;
              start_valid_r <= 1'b1;
              start_armed_r <= 1'b0;
            end
            if (!init_r) init_r <= 1'b1;
            i_r     <= '0;
            empty_r <= (active_r == '0);
          end
          default: begin
          end
        endcase
      end

      case (state_r)
        pqts_pkg::ST_SRCH_CMP: begin
          if (found) begin
            k_r    <= pqts_pkg::TOP_POWER;
            axis_r <= 1'b0;
            kind_r <= pqts_pkg::KIND_POS;
          end else begin
            i_r <= i_inc;
            if (last_seg) empty_r <= 1'b1;
          end
        end
        pqts_pkg::ST_FIRST: begin
          k_r <= k_r - 3'd1;
        end
        pqts_pkg::ST_ADD: begin
          if (k_r != low_k) k_r <= k_r - 3'd1;
        end
        pqts_pkg::ST_STORE: begin
          // advance to the next polynomial: pos, vel, acc, then the other axis
          k_r <= pqts_pkg::TOP_POWER;
          case (kind_r)
            pqts_pkg::KIND_POS: kind_r <= pqts_pkg::KIND_VEL;
            pqts_pkg::KIND_VEL: kind_r <= pqts_pkg::KIND_ACC;
            default: begin
              kind_r <= pqts_pkg::KIND_POS;
              axis_r <= 1'b1;
            end
          endcase
        end
        default: begin
        end
      endcase

      if (state_r == pqts_pkg::ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_acc && is_sample) begin
      dt_r     <= dt;
      prev_r   <= '0;
      meas_x_r <= in_meas_x;
      meas_y_r <= in_meas_y;
      meas_z_r <= in_meas_z;
    end
    if (state_r == pqts_pkg::ST_SRCH_CMP) begin
      if (found) begin
        tt_neg_r <= dt_r < prev_r;
        tt_mag_r <= (dt_r < prev_r) ? (prev_r - dt_r) : (dt_r - prev_r);
        seg_r    <= i_r[pqts_pkg::SEG_W-1:0];
      end else begin
        prev_r <= end_rd;
      end
    end
    if (state_r == pqts_pkg::ST_C_CAP) begin
      coef_r <= {{10{scaled[53]}}, scaled};
    end
    if (state_r == pqts_pkg::ST_STORE) begin
      res_r[res_idx] <= pqts_pkg::to_q16(acc);
    end
    if (state_r == pqts_pkg::ST_EMIT && out_free) begin
      o_ready_r <= !empty_r;
      o_traj_r  <= traj_r;
      o_pos_x_r <= empty_r ? meas_x_r : res_r[0];
      o_vel_x_r <= empty_r ? 32'd0 : res_r[1];
      o_acc_x_r <= empty_r ? 32'd0 : res_r[2];
      o_pos_y_r <= empty_r ? meas_y_r : res_r[3];
      o_vel_y_r <= empty_r ? 32'd0 : res_r[4];
      o_acc_y_r <= empty_r ? 32'd0 : res_r[5];
      o_pos_z_r <= empty_r ? meas_z_r : hold_height_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_ready_res         = o_ready_r;
  assign out_pos_x             = o_pos_x_r;
  assign out_pos_y             = o_pos_y_r;
  assign out_pos_z             = o_pos_z_r;
  assign out_vel_x             = o_vel_x_r;
  assign out_vel_y             = o_vel_y_r;
  assign out_acc_x             = o_acc_x_r;
  assign out_acc_y             = o_acc_y_r;
  assign out_trajectory_number = o_traj_r;

endmodule
